/* rtl/fau_pkg.sv */
// Package for the fraction arithmetic unit: operation codes and widths.
// No dependencies.
`default_nettype none
package fau_pkg;
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam int NUM_W = 33;
    localparam int DEN_W = 32;
    localparam int ACC_W = 64;
    typedef logic [ACC_W-1:0] t_word;
    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;
endpackage
`default_nettype wire

/* rtl/fau_divider.sv */
// Restoring divider, one quotient bit per cycle, on 64-bit magnitudes.
// Depends on fau_pkg.
`default_nettype none
module fau_divider (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire fau_pkg::t_word    i_dvd,
    input  wire fau_pkg::t_word    i_dvs,
    output logic                   o_done,
    output fau_pkg::t_word         o_quo,
    output fau_pkg::t_word         o_rem
);
    logic [6:0]              r_cnt;
    logic                    r_busy;
    fau_pkg::t_word          r_q;
    fau_pkg::t_word          r_r;
    fau_pkg::t_word          r_d;
    logic [fau_pkg::ACC_W:0] w_try;
    fau_pkg::t_word          w_sh;

    assign w_sh  = {r_r[fau_pkg::ACC_W-2:0], r_q[fau_pkg::ACC_W-1]};
    assign w_try = {1'b0, w_sh} - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_dvd;
                r_r    <= '0;
                r_d    <= i_dvs;
            end else if (r_busy) begin
                // shift in one dividend bit, subtract when it fits
                if (!w_try[fau_pkg::ACC_W]) begin
                    r_r <= w_try[fau_pkg::ACC_W-1:0];
                    r_q <= {r_q[fau_pkg::ACC_W-2:0], 1'b1};
                end else begin
                    r_r <= w_sh;
                    r_q <= {r_q[fau_pkg::ACC_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_q;
    assign o_rem = r_r;

`ifndef NO_ASSERTIONS
    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !r_busy) else $error("done while busy");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy) else $error("start did not begin");
    a_cnt_zero_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> r_cnt == 7'd0) else $error("count not cleared");
`endif
endmodule
`default_nettype wire

/* rtl/fraction_arith_unit.sv */
// Top level of the fraction arithmetic unit: sequencer, shared multiplier,
// shared divider. Depends on fau_pkg and fau_divider.
`default_nettype none
// One request at a time. Cross products go through a single registered
// WIDTH by WIDTH multiplier, the GCD runs Euclid on the shared
// restoring divider, and two more divisions reduce numerator and
// denominator. Compare requests end after the multiplier and error
// requests go straight to the result. i_out_stall is honored only once a
// result is held; a held result stalls the next request until it is
// transferred.
module fraction_arith_unit #(
    parameter int WIDTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire  [2:0]               i_req_type,
    input  wire  signed [WIDTH-1:0]  i_a_num,
    input  wire  signed [WIDTH-1:0]  i_a_den,
    input  wire  signed [WIDTH-1:0]  i_b_num,
    input  wire  signed [WIDTH-1:0]  i_b_den,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output logic signed [32:0]       o_res_num,
    output logic signed [31:0]       o_res_den,
    output logic signed [1:0]        o_cmp_result,
    output logic                     o_op_error
);
    localparam logic [3:0] S_IDLE = 4'd0, S_M0 = 4'd1, S_M1 = 4'd2, S_M2 = 4'd3,
                           S_M3 = 4'd4, S_FORM = 4'd5, S_GCD = 4'd6,
                           S_GWAIT = 4'd7, S_DN = 4'd8, S_DNW = 4'd9,
                           S_DD = 4'd10, S_DDW = 4'd11, S_OUT = 4'd12;
    logic [3:0]     r_st;
    logic [2:0]     r_op;
    fau_pkg::t_word r_an, r_ad, r_bn, r_bd, r_p0, r_p1, r_p2, r_num, r_den;
    fau_pkg::t_word r_x, r_y, r_g;
    logic signed [WIDTH-1:0]   r_ma, r_mb;
    logic signed [2*WIDTH-1:0] w_prod;
    fau_pkg::t_word r_prod;
    fau_pkg::t_word w_dvd, w_dvs, w_quo, w_rem;
    logic           w_dstart, w_ddone;
    fau_pkg::t_div_ctl w_ctl;

    function automatic fau_pkg::t_word f_sext(input logic [WIDTH-1:0] v);
        f_sext = fau_pkg::t_word'(signed'(v));
    endfunction
    function automatic fau_pkg::t_word f_mag(input fau_pkg::t_word v);
        f_mag = v[fau_pkg::ACC_W-1] ? (~v + 64'd1) : v;
    endfunction

    // shared multiplier: operands registered, product registered
    assign w_prod = r_ma * r_mb;
    always_ff @(posedge i_clk) r_prod <= fau_pkg::t_word'(w_prod);

    assign w_ctl.start = w_dstart;
    assign w_ctl.busy  = (r_st == S_GWAIT) || (r_st == S_DNW) || (r_st == S_DDW);

    fau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ctl.start),
        .i_dvd(w_dvd), .i_dvs(w_dvs), .o_done(w_ddone), .o_quo(w_quo), .o_rem(w_rem)
    );

    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_x;
        w_dvs    = r_y;
        unique case (r_st)
            S_GCD: w_dstart = (r_y != '0);
            S_DN: begin w_dstart = 1'b1; w_dvd = f_mag(r_num); w_dvs = r_g; end
            S_DD: begin w_dstart = 1'b1; w_dvd = f_mag(r_den); w_dvs = r_g; end
            default: w_dstart = 1'b0;
        endcase
    end

    assign o_in_stall = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_in_valid) begin
                    r_op <= i_req_type;
                    r_an <= f_sext(i_a_num); r_ad <= f_sext(i_a_den);
                    r_bn <= f_sext(i_b_num); r_bd <= f_sext(i_b_den);
                    r_ma <= i_a_num; r_mb <= i_b_den;
                    // drop straight to the result on any error
                    if (i_a_den == '0 || i_b_den == '0 || i_req_type > fau_pkg::OP_CMP ||
                        (i_req_type == fau_pkg::OP_DIV && i_b_num == '0)) begin
                        o_res_num <= '0; o_res_den <= '0; o_cmp_result <= '0;
                        o_op_error <= 1'b1; o_out_valid <= 1'b1; r_st <= S_OUT;
                    end else begin
                        r_st <= S_M0;
                    end
                end
                S_M0: begin r_ma <= r_bn[WIDTH-1:0]; r_mb <= r_ad[WIDTH-1:0]; r_st <= S_M1; end
                S_M1: begin r_p0 <= r_prod; r_ma <= r_ad[WIDTH-1:0];
                    r_mb <= (r_op == fau_pkg::OP_DIV) ? r_bn[WIDTH-1:0] : r_bd[WIDTH-1:0];
                    r_st <= S_M2; end
                S_M2: begin r_p1 <= r_prod; r_ma <= r_an[WIDTH-1:0]; r_mb <= r_bn[WIDTH-1:0];
                    r_st <= S_M3; end
                S_M3: begin r_p2 <= r_prod; r_st <= S_FORM; end
                S_FORM: begin
                    if (r_op == fau_pkg::OP_CMP) begin
                        // p0 = an*bd, p1 = bn*ad
                        logic signed [1:0] c;
                        c = ($signed(r_p1) < $signed(r_p0)) ? 2'sd1 :
                            ($signed(r_p0) < $signed(r_p1)) ? -2'sd1 : 2'sd0;
                        if (r_ad[fau_pkg::ACC_W-1] ^ r_bd[fau_pkg::ACC_W-1]) c = -c;
                        o_res_num <= '0; o_res_den <= '0; o_cmp_result <= c;
                        o_op_error <= 1'b0; o_out_valid <= 1'b1; r_st <= S_OUT;
                    end else begin
                        fau_pkg::t_word n;
                        case (r_op)
                            fau_pkg::OP_ADD: n = r_p0 + r_p1;
                            fau_pkg::OP_SUB: n = r_p0 - r_p1;
                            fau_pkg::OP_MUL: n = r_prod;
                            default:         n = r_p0;
                        endcase
                        // p2 holds ad*bd, or ad*bn for divide
                        r_num <= n; r_den <= r_p2;
                        r_x <= f_mag(n);
                        r_y <= f_mag(r_p2);
                        r_st <= S_GCD;
                    end
                end
                S_GCD: if (r_y == '0) begin
                    r_g <= (r_x == '0) ? 64'd1 : r_x; r_st <= S_DN;
                end else r_st <= S_GWAIT;
                S_GWAIT: if (w_ddone) begin
                    r_x <= r_y; r_y <= w_rem; r_st <= S_GCD;
                end
                S_DN: r_st <= S_DNW;
                S_DNW: if (w_ddone) begin
                    o_res_num <= r_num[fau_pkg::ACC_W-1] ? 33'(~w_quo + 64'd1) : 33'(w_quo);
                    r_st <= S_DD;
                end
                S_DD: r_st <= S_DDW;
                S_DDW: if (w_ddone) begin
                    o_res_den <= r_den[fau_pkg::ACC_W-1] ? 32'(~w_quo + 64'd1) : 32'(w_quo);
                    o_cmp_result <= '0; o_op_error <= 1'b0;
                    o_out_valid <= 1'b1; r_st <= S_OUT;
                end
                S_OUT: if (!i_out_stall) begin
                    o_out_valid <= 1'b0; r_st <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_valid_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_st == S_OUT) else $error("valid outside output state");
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_op_error) |-> (o_res_num == '0 && o_cmp_result == '0))
        else $error("error result not cleared");
    a_div_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ddone |-> w_ctl.busy) else $error("divider done outside wait");
`endif
endmodule
`default_nettype wire

/* sim/tb_top.sv */
// Self-checking bench for fraction_arith_unit: directed and random fraction requests
// with random idling on both sides. Depends on fau_pkg and the unit's RTL.
`default_nettype none
module tb_top;
    localparam int WIDTH = 16;
    localparam longint CYCLE_LIMIT = 20_000_000;
    localparam int TAIL_CYCLES = 400;
    localparam int N_RANDOM = 880;
    localparam int HOLD_AT = 400;     // transfers in before the long receiver hold
    localparam int HOLD_LEN = 3000;
    localparam int DRAIN_AT = 650;    // item that waits for an empty pipeline
    // Codes outside the defined operations; the unit flags them as errors.
    localparam logic [2:0] OP_RSV5 = 3'd5;
    localparam logic [2:0] OP_RSV6 = 3'd6;
    localparam logic [2:0] OP_RSV7 = 3'd7;

    typedef struct {
        logic [2:0]              op;
        logic signed [WIDTH-1:0] an, ad, bn, bd;
        bit                      wait_empty;
    } t_frac_req;

    typedef struct {
        logic signed [32:0] num;
        logic signed [31:0] den;
        logic signed [1:0]  cmp;
        logic               err;
    } t_frac_res;

    logic i_clk, i_rst_n;
    logic i_in_valid, i_out_stall;
    logic [2:0] i_req_type;
    logic signed [WIDTH-1:0] i_a_num, i_a_den, i_b_num, i_b_den;
    wire o_in_stall, o_out_valid, o_op_error;
    wire signed [32:0] o_res_num;
    wire signed [31:0] o_res_den;
    wire signed [1:0]  o_cmp_result;

    t_frac_req pending_reqs[$];
    t_frac_res expected_fracs[$];
    longint cycle_cnt = 0;
    int n_in = 0, n_out = 0, n_err = 0, n_fail = 0, n_cmp = 0;
    int in_gap, stall_left, hold_cnt;
    bit hold_done;

    fraction_arith_unit #(.WIDTH(WIDTH)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(i_req_type),
        .i_a_num(i_a_num), .i_a_den(i_a_den), .i_b_num(i_b_num), .i_b_den(i_b_den),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_res_num(o_res_num), .o_res_den(o_res_den),
        .o_cmp_result(o_cmp_result), .o_op_error(o_op_error)
    );

    // Exact rational result: cross products in 64 bits, reduce by GCD of magnitudes.
    function automatic t_frac_res reduce_fraction(t_frac_req r);
        longint an, ad, bn, bd, num, den, lhs, rhs, g;
        longint unsigned x, y, t;
        int c;
        t_frac_res res;
        an = r.an;
        ad = r.ad;
        bn = r.bn;
        bd = r.bd;
        res = '{num: '0, den: '0, cmp: '0, err: 1'b0};
        num = 0;
        den = 0;
        if (ad == 0 || bd == 0 || r.op > fau_pkg::OP_CMP ||
            (r.op == fau_pkg::OP_DIV && bn == 0)) begin
            res.err = 1'b1;
            return res;
        end
        if (r.op == fau_pkg::OP_CMP) begin
            lhs = an * bd;
            rhs = bn * ad;
            c = (lhs > rhs) ? 1 : (lhs < rhs) ? -1 : 0;
            // A negative denominator product flips the order.
            if ((ad < 0) != (bd < 0))
                c = -c;
            res.cmp = 2'(c);
            return res;
        end
        case (r.op)
            fau_pkg::OP_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
            fau_pkg::OP_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
            fau_pkg::OP_MUL: begin num = an * bn;           den = ad * bd; end
            default: begin num = an * bd;                   den = ad * bn; end
        endcase
        x = (num < 0) ? -num : num;
        y = (den < 0) ? -den : den;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        g = (x == 0) ? 1 : longint'(x);
        // Signed division truncates toward zero, so signs stay where they fall.
        res.num = 33'(num / g);
        res.den = 32'(den / g);
        return res;
    endfunction

    function automatic logic signed [WIDTH-1:0] pick_field(bit allow_zero);
        logic signed [WIDTH-1:0] v;
        do begin
            if ($urandom_range(0, 9) < 6)
                v = WIDTH'($signed($urandom_range(0, 200)) - 100);
            else
                v = WIDTH'($urandom);
        end while (!allow_zero && v == 0);
        return v;
    endfunction

    function automatic t_frac_req make_req(logic [2:0] op, int an, int ad, int bn, int bd);
        t_frac_req r;
        r.op = op;
        r.an = WIDTH'(an);
        r.ad = WIDTH'(ad);
        r.bn = WIDTH'(bn);
        r.bd = WIDTH'(bd);
        r.wait_empty = 1'b0;
        return r;
    endfunction

    // Clock and reset.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Fill the request queue: directed corners first, then mostly well-formed random requests.
    initial begin
        t_frac_req r;
        pending_reqs.push_back(make_req(fau_pkg::OP_ADD, 1, 2, 1, 3));
        pending_reqs.push_back(make_req(fau_pkg::OP_SUB, 1, 2, 1, 2));  // zero numerator
        pending_reqs.push_back(make_req(fau_pkg::OP_SUB, 1, -2, 1, 2)); // negative denominator
        pending_reqs.push_back(make_req(fau_pkg::OP_MUL, -32768, -32768, -32768, -32768));
        pending_reqs.push_back(make_req(fau_pkg::OP_MUL, 32767, 32767, -32768, 1));
        pending_reqs.push_back(make_req(fau_pkg::OP_ADD, 32767, 1, 32767, 1));
        pending_reqs.push_back(make_req(fau_pkg::OP_ADD, -32768, 1, -32768, 1));
        pending_reqs.push_back(make_req(fau_pkg::OP_SUB, -32768, 32767, 32767, -32768));
        pending_reqs.push_back(make_req(fau_pkg::OP_DIV, 3, 4, 5, 7));
        pending_reqs.push_back(make_req(fau_pkg::OP_DIV, 3, 4, 0, 7));  // divide by zero fraction
        pending_reqs.push_back(make_req(fau_pkg::OP_DIV, 0, -5, -32768, 3));
        pending_reqs.push_back(make_req(fau_pkg::OP_ADD, 1, 0, 1, 2));  // zero denominator
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, 1, 2, 1, 0));
        pending_reqs.push_back(make_req(fau_pkg::OP_MUL, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, 1, 2, 2, 4));  // equal values
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, 1, 2, 1, 3));
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, 1, -2, 1, 3));
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, -32768, 32767, 32767, -32768));
        pending_reqs.push_back(make_req(fau_pkg::OP_CMP, 5, -7, -5, 7));
        pending_reqs.push_back(make_req(OP_RSV5, 1, 2, 3, 4));          // unknown operations
        pending_reqs.push_back(make_req(OP_RSV6, 1, 2, 3, 4));
        pending_reqs.push_back(make_req(OP_RSV7, -1, -1, -1, -1));
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                r.op = 3'($urandom_range(fau_pkg::OP_ADD, fau_pkg::OP_CMP));
                r.ad = pick_field(1'b0);
                r.bd = pick_field(1'b0);
            end else begin
                r.op = 3'($urandom_range(0, 7));
                r.ad = ($urandom_range(0, 2) == 0) ? '0 : pick_field(1'b1);
                r.bd = ($urandom_range(0, 2) == 0) ? '0 : pick_field(1'b1);
            end
            r.an = ($urandom_range(0, 15) == 0) ? '0 : pick_field(1'b1);
            r.bn = ($urandom_range(0, 15) == 0) ? '0 : pick_field(1'b1);
            r.wait_empty = (pending_reqs.size() == DRAIN_AT);
            pending_reqs.push_back(r);
        end
    end

    // Random gap length: mostly short, a few long; none during quiet stretches.
    function automatic int gap_len();
        if (cycle_cnt[11:9] == 3'd0 || $urandom_range(0, 1) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
    endfunction

    // Driver: record each accepted transfer, then offer the next request after its gap.
    always @(posedge i_clk) begin
        logic nxt_valid;
        t_frac_req r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_req_type <= '0;
            i_a_num <= '0;
            i_a_den <= '0;
            i_b_num <= '0;
            i_b_den <= '0;
            in_gap <= 0;
        end else begin
            nxt_valid = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                r.op = i_req_type;
                r.an = i_a_num;
                r.ad = i_a_den;
                r.bn = i_b_num;
                r.bd = i_b_den;
                expected_fracs.push_back(reduce_fraction(r));
                n_in <= n_in + 1;
                nxt_valid = 1'b0;
            end
            // Hold a stalled payload; otherwise advance.
            if (!nxt_valid) begin
                if (in_gap > 0) begin
                    in_gap <= in_gap - 1;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].wait_empty && expected_fracs.size() != 0)) begin
                    r = pending_reqs.pop_front();
                    i_req_type <= r.op;
                    i_a_num <= r.an;
                    i_a_den <= r.ad;
                    i_b_num <= r.bn;
                    i_b_den <= r.bd;
                    nxt_valid = 1'b1;
                    in_gap <= gap_len();
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // Long receiver hold, timed in its own process, so the unit backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && n_in >= HOLD_AT) begin
            hold_cnt <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Monitor: check each result transfer against the oldest expectation; drive stall.
    always @(posedge i_clk) begin
        t_frac_res exp_r;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_out <= n_out + 1;
                if (expected_fracs.size() == 0) begin
                    n_fail <= n_fail + 1;
                    if (n_fail < 10)
                        $display("tb_top: result with no request pending: num=%0d den=%0d",
                                 o_res_num, o_res_den);
                end else begin
                    exp_r = expected_fracs.pop_front();
                    if (exp_r.err) n_err <= n_err + 1;
                    else if (exp_r.num == 0 && exp_r.den == 0) n_cmp <= n_cmp + 1;
                    if (o_res_num !== exp_r.num || o_res_den !== exp_r.den ||
                        o_cmp_result !== exp_r.cmp || o_op_error !== exp_r.err) begin
                        n_fail <= n_fail + 1;
                        if (n_fail < 10) begin
                            $display("tb_top: mismatch at result %0d: exp %0d/%0d cmp=%0d err=%0b",
                                     n_out, exp_r.num, exp_r.den, exp_r.cmp, exp_r.err);
                            $display("tb_top:   got %0d/%0d cmp=%0d err=%0b",
                                     o_res_num, o_res_den, o_cmp_result, o_op_error);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_stall <= 1'b1;
            end else begin
                stall_left <= gap_len();
                i_out_stall <= (hold_cnt > 1);
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_cnt);
            $display("tb_top: errors");
            $finish;
        end
    end

    initial begin
        @(posedge i_rst_n);
        // Drain: everything sent, everything back, then let the unit settle.
        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || i_in_valid || expected_fracs.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("tb_top: %0d requests sent, %0d results checked (%0d error, %0d compare/zero)",
                 n_in, n_out, n_err, n_cmp);
        $display("tb_top: %0d mismatches in %0d cycles", n_fail, cycle_cnt);
        if (n_fail == 0 && expected_fracs.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
rtl/fau_pkg.sv
rtl/fau_divider.sv
rtl/fraction_arith_unit.sv
sim/tb_top.sv
